@@ hdl/bsd_pkg.sv @@
// Shared constants, types and key function for the block sorter.
package bsd_pkg;
  localparam int unsigned BlockSize = 64;
  localparam int unsigned Depth = 64;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW = $clog2(QDepth);

  typedef struct packed {
    logic [63:0] value;
    logic        close;
  } entry_t;

  function automatic logic [63:0] order_key(input logic [63:0] b);
    logic nan;
    nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    if (nan || !b[63]) begin
      order_key = b | 64'h8000_0000_0000_0000;
    end else begin
      order_key = ~b;
    end
  endfunction
endpackage

@@ hdl/bsd_stream_if.sv @@
// Valid/ready channel carrying one word and its end mark.
interface bsd_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  logic        last;
  modport source (output valid, output data, output last, input ready);
  modport sink (input valid, input data, input last, output ready);
endinterface

@@ hdl/bsd_ram.sv @@
// Generic single-write RAM with one registered read port.
module bsd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hdl/bsd_front.sv @@
// Front end: marks block close on input words and feeds the queue.
module bsd_front import bsd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  bsd_stream_if.sink    in_if,
  output logic          q_push_o,
  output entry_t        q_data_o,
  input  logic          q_full_i
);
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            close;

  assign in_if.ready = !q_full_i;
  assign q_push_o    = in_if.valid && !q_full_i;
  assign close       = in_if.last || (cnt_q == CntW'(BlockSize - 1));
  assign q_data_o    = '{value: in_if.data, close: close};
  assign cnt_d       = close ? '0 : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (q_push_o) begin
      cnt_q <= cnt_d;
    end
  end
endmodule

@@ hdl/bsd_queue.sv @@
// Short FIFO between front end and sort engine.
module bsd_queue import bsd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t data_o,
  output logic   empty_o
);
  entry_t           mem_q [QDepth];
  logic [QIdxW:0]   wp_q, rp_q;

  assign empty_o = wp_q == rp_q;
  assign full_o  = (wp_q[QIdxW] != rp_q[QIdxW]) &&
                   (wp_q[QIdxW-1:0] == rp_q[QIdxW-1:0]);
  assign data_o  = mem_q[rp_q[QIdxW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q[QIdxW-1:0]] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
    end
  end
endmodule

@@ hdl/bsd_back.sv @@
// Sort engine: insertion sort in RAM on load, then stream out the block.
module bsd_back import bsd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_empty_i,
  input  entry_t       q_data_i,
  output logic         q_pop_o,
  bsd_stream_if.source out_if
);
  typedef enum logic [2:0] {
    ST_LOAD, ST_RD, ST_CMP, ST_ORD, ST_ORD2, ST_OUT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] n_q;
  logic [IdxW-1:0] j_q;
  logic [IdxW-1:0] k_q;
  logic [63:0]     cur_q;
  logic [63:0]     cur_key_q;
  logic            close_q;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [63:0]     wdata, rdata;
  logic            out_valid_q, out_last_q;
  logic [63:0]     out_data_q;

  bsd_ram #(.Width(64), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign q_pop_o      = (state_q == ST_LOAD) && !q_empty_i;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;
  assign out_if.last  = out_last_q;

  always_comb begin
    we    = 1'b0;
    waddr = j_q;
    wdata = cur_q;
    raddr = j_q - 1'b1;
    unique case (state_q)
      ST_CMP: begin
        we = 1'b1;
        if (j_q != '0 && order_key(rdata) > cur_key_q) begin
          wdata = rdata;
        end
        raddr = j_q - 2'd2;
      end
      ST_ORD, ST_ORD2, ST_OUT: raddr = k_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (!q_empty_i) begin
            cur_q     <= q_data_i.value;
            cur_key_q <= order_key(q_data_i.value);
            close_q   <= q_data_i.close;
            j_q       <= n_q[IdxW-1:0];
            n_q       <= n_q + 1'b1;
            state_q   <= ST_RD;
          end
        end
        ST_RD: state_q <= ST_CMP;
        ST_CMP: begin
          if (j_q != '0 && order_key(rdata) > cur_key_q) begin
            j_q     <= j_q - 1'b1;
            state_q <= ST_RD;
          end else if (close_q) begin
            k_q     <= '0;
            state_q <= ST_ORD;
          end else begin
            state_q <= ST_LOAD;
          end
        end
        ST_ORD: state_q <= ST_ORD2;
        ST_ORD2: begin
          out_valid_q <= 1'b1;
          out_data_q  <= rdata;
          out_last_q  <= (CntW'(k_q) + 1'b1) == n_q;
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_if.ready) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              n_q     <= '0;
              state_q <= ST_LOAD;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_ORD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end
endmodule

@@ hdl/block_sorter_doubles.sv @@
// Flow: the front end passes each word to the queue combinationally; the engine loads
// it, then reads and compares (ST_RD, ST_CMP), shifting one element per step until placed.
// Output: each word is read from the registered RAM read port (ST_ORD, ST_ORD2), then held in ST_OUT until ready.
// The engine takes no new word until the current one is placed and a closed block is out.
// Reset: asynchronous, active low; clears counters, queue and state; the
// element RAM is left undefined.
module block_sorter_doubles import bsd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  bsd_stream_if.sink   in_if,
  bsd_stream_if.source out_if
);
  logic   push, pop, full, empty;
  entry_t qin, qout;

  bsd_front u_front (
    .clk_i, .rst_ni, .in_if, .q_push_o(push), .q_data_o(qin), .q_full_i(full)
  );
  bsd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(qin), .full_o(full),
    .pop_i(pop), .data_o(qout), .empty_o(empty)
  );
  bsd_back u_back (
    .clk_i, .rst_ni, .q_empty_i(empty), .q_data_i(qout), .q_pop_o(pop), .out_if
  );
endmodule

@@ dv/block_sorter_doubles_tb.sv @@
// Testbench for block_sorter_doubles: random and directed blocks checked against a sorting predictor.
module block_sorter_doubles_tb;
  import bsd_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic        fin;
  } sorted_word_t;

  logic clk_i;
  logic rst_ni;

  bsd_stream_if in_ch ();
  bsd_stream_if out_ch ();

  block_sorter_doubles dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  logic [63:0]  open_block[$];
  sorted_word_t sorted_words[$];
  int           fail_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  logic [63:0]  prev_value = 64'd0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] sort_key(input logic [63:0] b);
    if (b[62:52] == 11'h7FF && b[51:0] != 52'd0) return {1'b1, b[62:0]};
    if (b[63]) return ~b;
    return {1'b1, b[62:0]};
  endfunction

  // sort the open block and queue its words
  task automatic close_block();
    logic [63:0] arr[$];
    logic [63:0] cur;
    int j;
    arr = open_block;
    for (int i = 1; i < arr.size(); i++) begin
      cur = arr[i];
      j = i;
      while (j > 0 && sort_key(arr[j-1]) > sort_key(cur)) begin
        arr[j] = arr[j-1];
        j--;
      end
      arr[j] = cur;
    end
    for (int k = 0; k < arr.size(); k++) begin
      sorted_words.push_back('{value: arr[k], fin: (k == arr.size() - 1)});
    end
    open_block.delete();
  endtask

  task automatic send_word(input logic [63:0] v, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= v;
    in_ch.last  <= l;
    do @(posedge clk_i); while (!in_ch.ready);
    open_block.push_back(v);
    prev_value = v;
    if (l || open_block.size() == BlockSize) close_block();
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(7))
      0: v = prev_value;
      1: v = {v[63], 11'h7FF, v[51:1], 1'b1};
      2: v = {v[63], 11'h7FF, 52'd0};
      3: v = {v[63], 63'd0};
      4: v = {v[63], 11'd0, v[51:0]};
      5: v = prev_value ^ (64'd1 << $urandom_range(63));
      default: ;
    endcase
    return v;
  endfunction

  // accept and check sorted words
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (sorted_words.size() == 0) begin
        $error("unexpected word sorted_value=%h final=%b", out_ch.data, out_ch.last);
        fail_count++;
      end else begin
        if (out_ch.data != sorted_words[0].value &&
            sort_key(out_ch.data) == sort_key(sorted_words[0].value)) begin
          // equal keys may come out in any order
          for (int i = 1; i < sorted_words.size(); i++) begin
            if (sorted_words[i].value == out_ch.data) begin
              sorted_words[i].value = sorted_words[0].value;
              sorted_words[0].value = out_ch.data;
              break;
            end
            if (sorted_words[i].fin) break;
          end
        end
        if (out_ch.data != sorted_words[0].value) begin
          $error("sorted_value expected %h actual %h", sorted_words[0].value, out_ch.data);
          fail_count++;
        end
        if (out_ch.last != sorted_words[0].fin) begin
          $error("final_res expected %b actual %b", sorted_words[0].fin, out_ch.last);
          fail_count++;
        end
        void'(sorted_words.pop_front());
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic test_special_values();
    send_word(64'h0000_0000_0000_0000, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'h7FF0_0000_0000_0000, 1'b0);
    send_word(64'hFFF0_0000_0000_0000, 1'b0);
    send_word(64'h7FF8_0000_0000_0000, 1'b0);
    send_word(64'h7FF0_0000_0000_0001, 1'b0);
    send_word(64'hFFF0_0000_0000_0001, 1'b0);
    send_word(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'h0000_0000_0000_0001, 1'b0);
    send_word(64'h8000_0000_0000_0001, 1'b0);
    send_word(64'h3FF0_0000_0000_0000, 1'b1);
  endtask

  task automatic test_small_blocks();
    send_word(64'h4000_0000_0000_0000, 1'b1);
    send_word(64'hC000_0000_0000_0000, 1'b0);
    send_word(64'hC000_0000_0000_0000, 1'b1);
    send_word(64'h7FF0_0000_0000_0002, 1'b0);
    send_word(64'hFFF0_0000_0000_0002, 1'b0);
    send_word(64'h0000_0000_0000_0000, 1'b1);
  endtask

  task automatic test_full_block();
    for (int i = 0; i < BlockSize; i++) send_word(pick_value(), 1'b0);
  endtask

  task automatic test_random_blocks(input int words);
    int n;
    int sent;
    sent = 0;
    while (sent < words) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(BlockSize, 9) : $urandom_range(8, 1);
      if (n > words - sent) n = words - sent;
      for (int i = 0; i < n; i++) begin
        send_word(pick_value(), (i == n - 1));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int words);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    test_random_blocks(words);
  endtask

  initial begin
    int waited;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = 64'd0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_values();
    test_small_blocks();
    run_phase(0, 0, 6);
    run_phase(68, 0, 6);
    test_full_block();
    run_phase(0, 68, 6);
    run_phase(28, 28, 6);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (sorted_words.size() != 0 && waited < 500_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && sorted_words.size() == 0 && open_block.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
